### hdl/task_priority_queue_macros.svh
// assertion macros for the task priority queue checker
// used by tpq_checker.sv, needs a signal named clock and one named reset in scope
`ifndef TASK_PRIORITY_QUEUE_MACROS_SVH
`define TASK_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TPQ_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TPQ_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### hdl/tpq_pkg.sv
// shared types and codes for the task priority queue
// no dependencies; used by the cell, the top level, the checker and the testbench
package tpq_pkg;

   localparam int ID_BITS    = 8;
   localparam int KEY_BITS   = 8;
   localparam int TOTAL_BITS = 5;

   localparam logic [2:0] REQ_SORTED = 3'd0;
   localparam logic [2:0] REQ_FRONT  = 3'd1;
   localparam logic [2:0] REQ_BACK   = 3'd2;
   localparam logic [2:0] REQ_POLL   = 3'd3;
   localparam logic [2:0] REQ_PEEK   = 3'd4;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [ID_BITS-1:0]  task_id;
      logic [KEY_BITS-1:0] priority_req;
   } tpq_req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    head_task;
      logic                  head_valid;
      logic [TOTAL_BITS-1:0] entry_total;
      logic                  insert_dropped;
   } tpq_rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_SCAN   = 3'd1,
      CELL_SORTED = 3'd2,
      CELL_FRONT  = 3'd3,
      CELL_BACK   = 3'd4,
      CELL_POLL   = 3'd5
   } tpq_cell_op_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      tpq_cell_op_type     op;
      logic [ID_BITS-1:0]  task_id;
      logic [KEY_BITS-1:0] key_val;
   } tpq_cell_ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic [ID_BITS-1:0]  task_id;
      logic [KEY_BITS-1:0] key_val;
      logic                valid;
      logic                le;
      logic                hit;
   } tpq_link_type;

endpackage

### hdl/task_priority_queue.sv
// sequence: idle captures the request, the scan state walks the duplicate-id scan
// one cell per cycle down the chain, then the apply state updates the slots and
// registers the result strobe; busy blocks a new start until the return to idle; the receiver cannot stall
// reset: synchronous, clears the entry count, sequencer and strobe; slot contents kept
// depends on tpq_pkg and tpq_cell
module task_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tpq_pkg::tpq_req_type req_data,
   output logic                 rsp_strobe,
   output tpq_pkg::tpq_rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [SW-1:0] LAST_C  = SW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        scan_ff, scan_in;
   logic [CW-1:0]        count_ff, count_in;
   tpq_pkg::tpq_req_type req_ff, req_in;
   tpq_pkg::tpq_rsp_type rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   tpq_pkg::tpq_cell_ctl_type ctl;
   tpq_pkg::tpq_cell_op_type  apply_op;
   tpq_pkg::tpq_link_type     links [DEPTH];
   tpq_pkg::tpq_link_type     edge_link;

   logic                          full, empty, dup;
   logic [tpq_pkg::ID_BITS-1:0]   head;
   logic                          head_ok, dropped;

   assign full  = count_ff == DEPTH_C;
   assign empty = count_ff == '0;
   assign dup   = links[DEPTH-1].hit;

   // decide the operation once the scan is complete
   always_comb begin
      apply_op = tpq_pkg::CELL_HOLD;
      count_in = count_ff;
      head     = '0;
      head_ok  = 1'b0;
      dropped  = 1'b0;
      case (req_ff.req_type)
         tpq_pkg::REQ_SORTED, tpq_pkg::REQ_FRONT: begin
            if (full) begin
               dropped = 1'b1;
            end else begin
               apply_op = (req_ff.req_type == tpq_pkg::REQ_SORTED) ?
                          tpq_pkg::CELL_SORTED : tpq_pkg::CELL_FRONT;
               count_in = count_ff + CW'(1);
            end
         end
         tpq_pkg::REQ_BACK: begin
            if (!dup) begin
               if (full) begin
                  dropped = 1'b1;
               end else begin
                  apply_op = tpq_pkg::CELL_BACK;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         tpq_pkg::REQ_POLL: begin
            if (!empty) begin
               head     = links[0].task_id;
               head_ok  = 1'b1;
               apply_op = tpq_pkg::CELL_POLL;
               count_in = count_ff - CW'(1);
            end
         end
         tpq_pkg::REQ_PEEK: begin
            if (!empty) begin
               head    = links[0].task_id;
               head_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      ctl.op      = tpq_pkg::CELL_HOLD;
      ctl.task_id = req_ff.task_id;
      ctl.key_val = req_ff.priority_req;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.op = tpq_pkg::CELL_SCAN;
            if (scan_ff == LAST_C) begin
               state_in = ST_APPLY;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         ST_APPLY: begin
            ctl.op                = apply_op;
            rsp_in.head_task      = head;
            rsp_in.head_valid     = head_ok;
            rsp_in.entry_total    = tpq_pkg::TOTAL_BITS'(count_in);
            rsp_in.insert_dropped = dropped;
            strobe_in             = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      scan_ff <= scan_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (state_ff == ST_APPLY) begin
            count_ff <= count_in;
         end
      end
   end

   // what lies beyond either end of the chain: the new entry, always valid and le
   assign edge_link.task_id = req_ff.task_id;
   assign edge_link.key_val = req_ff.priority_req;
   assign edge_link.valid   = 1'b1;
   assign edge_link.le      = 1'b1;
   assign edge_link.hit     = 1'b0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      tpq_pkg::tpq_link_type left_l, right_l;
      if (g == 0) begin : g_first
         assign left_l = edge_link;
      end else begin : g_inner_l
         assign left_l = links[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_l = edge_link;
      end else begin : g_inner_r
         assign right_l = links[g+1];
      end
      tpq_cell #(
         .DEPTH (DEPTH),
         .IDX   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .count      (count_ff),
         .left_link  (left_l),
         .right_link (right_l),
         .link       (links[g])
      );
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hdl/tpq_cell.sv
// one slot of the ordered queue: holds an id, a key, a duplicate-scan bit and a key-compare bit
// depends on tpq_pkg for the control and neighbor link structs
module tpq_cell #(
   parameter int DEPTH = 16,
   parameter int IDX   = 0,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tpq_pkg::tpq_cell_ctl_type ctl,
   input  logic [CW-1:0]            count,
   input  tpq_pkg::tpq_link_type    left_link,
   input  tpq_pkg::tpq_link_type    right_link,
   output tpq_pkg::tpq_link_type    link
);

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic [tpq_pkg::ID_BITS-1:0]  task_ff, task_in;
   logic [tpq_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic                         hit_ff, hit_in;
   logic                         le_ff, le_in;
   logic                         valid, match, le;

   assign valid = count > IDX_C;
   assign match = valid && (task_ff == ctl.task_id);
   // own compare only; le_ff ands it along the chain so just the leading run is set
   assign le    = valid && (key_ff <= ctl.key_val);

   always_comb begin
      task_in = task_ff;
      key_in  = key_ff;
      hit_in  = 1'b0;
      le_in   = le_ff;
      case (ctl.op)
         tpq_pkg::CELL_SCAN: begin
            hit_in = left_link.hit | match;
            le_in  = left_link.le & le;
         end
         tpq_pkg::CELL_SORTED: begin
            if (!left_link.le) begin
               task_in = left_link.task_id;
               key_in  = left_link.key_val;
            end else if (!le_ff) begin
               task_in = ctl.task_id;
               key_in  = ctl.key_val;
            end
         end
         tpq_pkg::CELL_FRONT: begin
            task_in = left_link.task_id;
            key_in  = left_link.key_val;
         end
         tpq_pkg::CELL_BACK: begin
            if (left_link.valid && !valid) begin
               task_in = ctl.task_id;
               key_in  = ctl.key_val;
            end
         end
         tpq_pkg::CELL_POLL: begin
            task_in = right_link.task_id;
            key_in  = right_link.key_val;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
      key_ff  <= key_in;
      if (reset) begin
         hit_ff <= 1'b0;
         le_ff  <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         le_ff  <= le_in;
      end
   end

   assign link.task_id = task_ff;
   assign link.key_val = key_ff;
   assign link.valid   = valid;
   assign link.le      = le_ff;
   assign link.hit     = hit_ff;

endmodule

### hdl/tpq_checker.sv
// port-level checks for task_priority_queue, attached by the bind below
// depends on tpq_pkg and task_priority_queue_macros.svh
`include "task_priority_queue_macros.svh"

module tpq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input tpq_pkg::tpq_rsp_type rsp_data
);

   logic accept;
   logic head_shown;
   assign accept     = start && !busy;
   assign head_shown = rsp_strobe && rsp_data.head_valid;

   `TPQ_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
   `TPQ_ASSERT_NOW(a_rsp_idle, rsp_strobe, !busy, "result shown while still busy")
   `TPQ_ASSERT_NOW(a_rsp_after_busy, rsp_strobe, $past(busy), "result without a busy cycle")
   `TPQ_ASSERT_NOW(a_head_no_drop, head_shown, !rsp_data.insert_dropped, "head and drop flag")

endmodule

bind task_priority_queue tpq_checker u_tpq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### tb/task_priority_queue_tb.sv
// self-checking testbench for task_priority_queue: directed table, then random traffic
// depends on tpq_pkg and the task_priority_queue rtl; results checked against a local model
module task_priority_queue_tb;

   localparam int QUEUE_DEPTH = 16;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 4;
   localparam int PHASE_ITEMS = 564;

   // request codes with no operation behind them
   localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

   typedef struct {
      tpq_pkg::tpq_req_type item;
      int                   reps;
      bit                   typed;
      tpq_pkg::tpq_rsp_type want;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   tpq_pkg::tpq_req_type req_data = '0;
   logic                 rsp_strobe;
   tpq_pkg::tpq_rsp_type rsp_data;

   // typed expectation that rides along with the transaction being offered
   bit                   fixed_on = 1'b0;
   tpq_pkg::tpq_rsp_type fixed_rsp = '0;

   logic [tpq_pkg::ID_BITS-1:0]  queued_task [QUEUE_DEPTH];
   logic [tpq_pkg::KEY_BITS-1:0] queued_key  [QUEUE_DEPTH];
   int                           queued_count = 0;

   tpq_pkg::tpq_rsp_type pending_rsp [$];
   tpq_pkg::tpq_rsp_type model_rsp;
   tpq_pkg::tpq_rsp_type head_rsp;
   int                   fail_count = 0;
   int                   insert_pct = 50;

   task_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic tpq_pkg::tpq_rsp_type response(
         logic [tpq_pkg::ID_BITS-1:0] head, logic valid,
         logic [tpq_pkg::TOTAL_BITS-1:0] total, logic dropped);
      tpq_pkg::tpq_rsp_type r;
      r.head_task      = head;
      r.head_valid     = valid;
      r.entry_total    = total;
      r.insert_dropped = dropped;
      return r;
   endfunction

   function automatic plan_row_type plan_row(logic [2:0] op, logic [tpq_pkg::ID_BITS-1:0] id,
                                             logic [tpq_pkg::KEY_BITS-1:0] key, int reps,
                                             bit typed, tpq_pkg::tpq_rsp_type want);
      plan_row_type p;
      p.item.req_type     = op;
      p.item.task_id      = id;
      p.item.priority_req = key;
      p.reps              = reps;
      p.typed             = typed;
      p.want              = want;
      return p;
   endfunction

   function automatic void insert_at(int pos, logic [tpq_pkg::ID_BITS-1:0] id,
                                     logic [tpq_pkg::KEY_BITS-1:0] key);
      for (int i = queued_count; i > pos; i--) begin
         queued_task[i] = queued_task[i-1];
         queued_key[i]  = queued_key[i-1];
      end
      queued_task[pos] = id;
      queued_key[pos]  = key;
      queued_count++;
   endfunction

   function automatic tpq_pkg::tpq_rsp_type predict_response(tpq_pkg::tpq_req_type r);
      tpq_pkg::tpq_rsp_type res;
      int                   pos;
      bit                   dup;
      res = '0;
      pos = 0;
      dup = 1'b0;
      case (r.req_type)
         tpq_pkg::REQ_SORTED: begin
            if (queued_count >= QUEUE_DEPTH) begin
               res.insert_dropped = 1'b1;
            end else begin
               while (pos < queued_count && queued_key[pos] <= r.priority_req) pos++;
               insert_at(pos, r.task_id, r.priority_req);
            end
         end
         tpq_pkg::REQ_FRONT: begin
            if (queued_count >= QUEUE_DEPTH) res.insert_dropped = 1'b1;
            else insert_at(0, r.task_id, r.priority_req);
         end
         tpq_pkg::REQ_BACK: begin
            for (int i = 0; i < queued_count; i++)
               if (queued_task[i] == r.task_id) dup = 1'b1;
            // a queued id wins over a full queue: no drop flag
            if (!dup) begin
               if (queued_count >= QUEUE_DEPTH) res.insert_dropped = 1'b1;
               else insert_at(queued_count, r.task_id, r.priority_req);
            end
         end
         tpq_pkg::REQ_POLL: begin
            if (queued_count > 0) begin
               res.head_task  = queued_task[0];
               res.head_valid = 1'b1;
               for (int i = 1; i < queued_count; i++) begin
                  queued_task[i-1] = queued_task[i];
                  queued_key[i-1]  = queued_key[i];
               end
               queued_count--;
            end
         end
         tpq_pkg::REQ_PEEK: begin
            if (queued_count > 0) begin
               res.head_task  = queued_task[0];
               res.head_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.entry_total = queued_count[tpq_pkg::TOTAL_BITS-1:0];
      return res;
   endfunction

   function automatic tpq_pkg::tpq_req_type random_request();
      tpq_pkg::tpq_req_type r;
      int                   sel;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         r.req_type = REQ_UNUSED_LO + 3'($urandom_range(0, 2));
      end else if (sel < 3 + insert_pct) begin
         case ($urandom_range(0, 2))
            0: r.req_type = tpq_pkg::REQ_SORTED;
            1: r.req_type = tpq_pkg::REQ_FRONT;
            default: r.req_type = tpq_pkg::REQ_BACK;
         endcase
      end else if ($urandom_range(0, 4) != 0) begin
         r.req_type = tpq_pkg::REQ_POLL;
      end else begin
         r.req_type = tpq_pkg::REQ_PEEK;
      end
      // narrow ranges make duplicate ids and equal keys common
      r.task_id      = $urandom_range(0, 1) ? tpq_pkg::ID_BITS'($urandom_range(0, 15))
                                            : tpq_pkg::ID_BITS'($urandom_range(0, 255));
      r.priority_req = $urandom_range(0, 1) ? tpq_pkg::KEY_BITS'($urandom_range(0, 3))
                                            : tpq_pkg::KEY_BITS'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic check_field(string name, logic [tpq_pkg::ID_BITS-1:0] want,
                              logic [tpq_pkg::ID_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(tpq_pkg::tpq_req_type item, bit typed,
                               tpq_pkg::tpq_rsp_type want);
      req_data  <= item;
      fixed_on  <= typed;
      fixed_rsp <= want;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               head_rsp = pending_rsp.pop_front();
               check_field("head_task", head_rsp.head_task, rsp_data.head_task);
               check_field("head_valid", tpq_pkg::ID_BITS'(head_rsp.head_valid),
                           tpq_pkg::ID_BITS'(rsp_data.head_valid));
               check_field("entry_total", tpq_pkg::ID_BITS'(head_rsp.entry_total),
                           tpq_pkg::ID_BITS'(rsp_data.entry_total));
               check_field("insert_dropped", tpq_pkg::ID_BITS'(head_rsp.insert_dropped),
                           tpq_pkg::ID_BITS'(rsp_data.insert_dropped));
            end
         end
         if (start && !busy) begin
            // model state always advances, typed rows only override the expectation
            model_rsp = predict_response(req_data);
            pending_rsp.push_back(fixed_on ? fixed_rsp : model_rsp);
         end
      end
   end

   initial begin
      plan_row_type         plan [$];
      int                   idle_pct [3];
      tpq_pkg::tpq_rsp_type none;
      tpq_pkg::tpq_rsp_type nil_rsp;
      none = '0;
      nil_rsp = response(8'h00, 1'b0, 5'd0, 1'b0);
      idle_pct = '{21, 46, 0};

      plan.push_back(plan_row(tpq_pkg::REQ_POLL, 8'h00, 8'h00, 1, 1'b1, nil_rsp));
      plan.push_back(plan_row(tpq_pkg::REQ_PEEK, 8'hff, 8'hff, 1, 1'b1, nil_rsp));
      plan.push_back(plan_row(REQ_UNUSED_LO, 8'h12, 8'h34, 1, 1'b1, nil_rsp));
      plan.push_back(plan_row(REQ_UNUSED_HI, 8'hff, 8'hff, 1, 1'b1, nil_rsp));
      plan.push_back(plan_row(tpq_pkg::REQ_SORTED, 8'hff, 8'hff, 1, 1'b1,
                              response(8'h00, 1'b0, 5'd1, 1'b0)));
      plan.push_back(plan_row(tpq_pkg::REQ_SORTED, 8'h00, 8'h00, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_SORTED, 8'h11, 8'h80, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_SORTED, 8'h22, 8'h80, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_FRONT, 8'h33, 8'hff, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_BACK, 8'h44, 8'h00, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_BACK, 8'h44, 8'h7f, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_PEEK, 8'h00, 8'h00, 1, 1'b0, none));
      plan.push_back(plan_row(REQ_UNUSED_MID, 8'hff, 8'hff, 1, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_POLL, 8'hff, 8'hff, 7, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_SORTED, 8'ha5, 8'h5a, 16, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_SORTED, 8'h01, 8'h00, 1, 1'b1,
                              response(8'h00, 1'b0, 5'd16, 1'b1)));
      plan.push_back(plan_row(tpq_pkg::REQ_FRONT, 8'h02, 8'hff, 1, 1'b1,
                              response(8'h00, 1'b0, 5'd16, 1'b1)));
      plan.push_back(plan_row(tpq_pkg::REQ_BACK, 8'h03, 8'h01, 1, 1'b1,
                              response(8'h00, 1'b0, 5'd16, 1'b1)));
      plan.push_back(plan_row(tpq_pkg::REQ_BACK, 8'ha5, 8'h00, 1, 1'b1,
                              response(8'h00, 1'b0, 5'd16, 1'b0)));
      plan.push_back(plan_row(tpq_pkg::REQ_PEEK, 8'h00, 8'h00, 1, 1'b1,
                              response(8'ha5, 1'b1, 5'd16, 1'b0)));
      plan.push_back(plan_row(tpq_pkg::REQ_POLL, 8'h00, 8'h00, 16, 1'b0, none));
      plan.push_back(plan_row(tpq_pkg::REQ_POLL, 8'h00, 8'h00, 1, 1'b1, nil_rsp));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r])
         for (int n = 0; n < plan[r].reps; n++)
            send_request(plan[r].item, plan[r].typed, plan[r].want);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // alternate fill-heavy and drain-heavy stretches so the count sweeps 0 to full
            if (n % 40 == 0) insert_pct = (n % 80 == 0) ? 78 : 24;
            if ($urandom_range(0, 99) < idle_pct[phase]) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 24)) @(negedge clock);
            end
            send_request(random_request(), 1'b0, none);
         end
         // hold off until every outstanding transaction has answered
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
